>>> sv/ppt_pkg.sv
// Shared types, constants and the peak-join function of the parabolic peak tracker.
// Used by ppt_ctrl, ppt_dpath and parabolic_peak_tracker; depends on nothing.
package ppt_pkg;

    localparam int SAMPLE_W  = 24;   // Q1.23 sample
    localparam int PEAK_W    = 24;   // unsigned Q1.23 peak
    localparam int FIT_W     = 26;   // curvature and interpolated value
    localparam int NDIFF_W   = 25;   // y0 - y2
    localparam int SQ_W      = 49;   // n * n
    localparam int DEN_W     = 29;   // 8 * |d|
    localparam int QUO_W     = 24;   // quotient bits produced by the divider
    localparam int DIV_STEPS = 24;
    localparam int CNT_W     = 5;
    localparam int OP_W      = 2;

    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR_PEAK = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 2'd2;

    typedef struct packed {
        logic accept;     // take the input beat
        logic mul;        // square n, resolve flat parabola
        logic div_init;   // load divider
        logic div_step;   // one quotient bit
        logic join_fit;   // join the interpolated extremum
    } ppt_cmd_t;

    typedef struct packed {
        logic d_zero;
        logic in_span;
    } ppt_status_t;

    // Saturated magnitude of value joined into the running peak.
    function automatic logic [PEAK_W-1:0] join_peak(input logic [PEAK_W-1:0] peak,
                                                    input logic signed [FIT_W-1:0] value);
        logic [FIT_W-1:0]  mag;
        logic [PEAK_W-1:0] sat;
        mag = value[FIT_W-1] ? FIT_W'(-value) : FIT_W'(value);
        sat = (mag > FIT_W'(PEAK_MAX)) ? PEAK_MAX : mag[PEAK_W-1:0];
        return (sat > peak) ? sat : peak;
    endfunction

endpackage

>>> sv/parabolic_peak_tracker.sv
// Top level of the parabolic peak tracker: controller, datapath and output register.
// Depends on ppt_pkg, ppt_ctrl and ppt_dpath.
//
// Usage. Input beats arrive on the s_ group. s_tuser carries the operation: new sample,
// clear the peak only, or clear peak, window and group phase (the unused code changes
// nothing). s_tdata carries the signed Q1.23 sample, which is read only for a new sample.
// Every input beat produces exactly one output beat on the m_ group, whose m_tdata is
// the running peak magnitude in unsigned Q1.23 after that operation, saturating at
// full scale.
//
// Timing. The block works on one beat at a time. A clear or the unused code has its
// result waiting in the cycle after acceptance. A new sample passes the squaring state
// and then waits with its result when the parabola is flat or its extremum falls
// outside the half-sample span; else it goes on through the divider load, the 24-step
// restoring divider forming the correction term n*n/(8|d|), and the join. The next beat
// is accepted in the cycle after the result has been written into the output register.
//
// Reset clears the window, group phase, peak and output valid flag, not m_tdata. If the
// receiver stalls, the result holds in the output register; the block still accepts
// and works on one more beat, and then waits with that result until the register frees.
module parabolic_peak_tracker #(
    parameter int GROUP_LEN = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ppt_pkg::SAMPLE_W-1:0]      s_tdata,   // [23:0] sample
    input  logic [ppt_pkg::OP_W-1:0]          s_tuser,   // [1:0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppt_pkg::PEAK_W-1:0]        m_tdata    // [23:0] peak_level
);
    import ppt_pkg::*;

    ppt_cmd_t          cmd;
    ppt_status_t       status;
    logic              emit;
    logic              out_free;
    logic [PEAK_W-1:0] peak;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [PEAK_W-1:0] m_tdata_reg;

    // The output register may take a new result when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .status   (status),
        .out_free (out_free),
        .s_tready (s_tready),
        .cmd      (cmd),
        .emit     (emit)
    );

    ppt_dpath #(
        .GROUP_LEN (GROUP_LEN)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op     (s_tuser),
        .sample (s_tdata),
        .status (status),
        .peak   (peak)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // The peak register is final by the time the controller issues emit.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= peak;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!m_tvalid_reg || m_tready))
        else $error("Result written over an undelivered beat.");

endmodule

>>> sv/ppt_ctrl.sv
// Controller state machine of the parabolic peak tracker: sequences accept,
// squaring, the bit-serial division and result delivery. Depends on ppt_pkg.
module ppt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic [ppt_pkg::OP_W-1:0] op,
    input  ppt_pkg::ppt_status_t   status,
    input  logic                   out_free,
    output logic                   s_tready,
    output ppt_pkg::ppt_cmd_t      cmd,
    output logic                   emit
);
    import ppt_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIVI = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_JOIN = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        emit       = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (op == OP_SAMPLE) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = (status.d_zero || !status.in_span) ? ST_DONE : ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_JOIN;
                end
            end
            ST_JOIN:
            begin
                cmd.join_fit = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.mul, cmd.div_init, cmd.div_step, cmd.join_fit}))
        else $error("More than one datapath command in a cycle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> !s_tready)
        else $error("Block still ready after accepting a beat.");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg < CNT_W'(DIV_STEPS))
        else $error("Division step counter out of range.");

endmodule

>>> sv/ppt_dpath.sv
// Datapath of the parabolic peak tracker: window, group phase, peak register,
// squarer and bit-serial restoring divider. Depends on ppt_pkg.
module ppt_dpath #(
    parameter int GROUP_LEN = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ppt_pkg::ppt_cmd_t               cmd,
    input  logic [ppt_pkg::OP_W-1:0]        op,
    input  logic signed [ppt_pkg::SAMPLE_W-1:0] sample,
    output ppt_pkg::ppt_status_t            status,
    output logic [ppt_pkg::PEAK_W-1:0]      peak
);
    import ppt_pkg::*;

    localparam int PHASE_W = $clog2(GROUP_LEN);

    logic signed [SAMPLE_W-1:0] win0_reg, win1_reg, y1_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PEAK_W-1:0]          peak_reg;
    logic signed [FIT_W-1:0]    d_reg;
    logic signed [NDIFF_W-1:0]  n_reg;
    logic [SQ_W-1:0]            nsq_reg;
    logic [DEN_W-1:0]           rem_reg, den_reg;
    logic [QUO_W-1:0]           dvd_reg, quo_reg;

    logic signed [FIT_W-1:0]    d_new;
    logic signed [NDIFF_W-1:0]  n_new;
    logic signed [FIT_W:0]      d_ext, n_ext, ad_ext;
    logic [FIT_W-1:0]           ad;
    logic signed [2*NDIFF_W-1:0] prod;
    logic [SQ_W:0]              dividend;
    logic [DEN_W:0]             trial;
    logic                       take;
    logic signed [FIT_W-1:0]    fit_value;

    always_comb
    begin
        d_new = {{2{win0_reg[SAMPLE_W-1]}}, win0_reg}
              - {win1_reg[SAMPLE_W-1], win1_reg, 1'b0}
              + {{2{sample[SAMPLE_W-1]}}, sample};
        n_new = {win0_reg[SAMPLE_W-1], win0_reg} - {sample[SAMPLE_W-1], sample};

        d_ext  = {d_reg[FIT_W-1], d_reg};
        n_ext  = {{2{n_reg[NDIFF_W-1]}}, n_reg};
        ad_ext = d_reg[FIT_W-1] ? -d_ext : d_ext;
        ad     = ad_ext[FIT_W-1:0];

        status.d_zero = (d_reg == '0);
        if (!d_reg[FIT_W-1])
        begin
            status.in_span = (n_ext >= -ad_ext) && (n_ext < ad_ext);
        end
        else
        begin
            status.in_span = (n_ext > -ad_ext) && (n_ext <= ad_ext);
        end

        prod     = n_reg * n_reg;
        dividend = {1'b0, nsq_reg} + (SQ_W + 1)'({ad, 2'b00});

        trial = {rem_reg, dvd_reg[QUO_W-1]};
        take  = (trial >= {1'b0, den_reg});

        fit_value = d_reg[FIT_W-1]
                  ? ({{2{y1_reg[SAMPLE_W-1]}}, y1_reg} + {2'b00, quo_reg})
                  : ({{2{y1_reg[SAMPLE_W-1]}}, y1_reg} - {2'b00, quo_reg});
    end

    // Control state: window, group phase and peak.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg  <= '0;
            win1_reg  <= '0;
            phase_reg <= '0;
            peak_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            case (op)
                OP_SAMPLE:
                begin
                    if (phase_reg == '0)
                    begin
                        peak_reg <= join_peak(peak_reg,
                                              {{2{win0_reg[SAMPLE_W-1]}}, win0_reg});
                    end
                    win0_reg <= win1_reg;
                    win1_reg <= sample;
                    if (phase_reg >= PHASE_W'(GROUP_LEN - 1))
                    begin
                        phase_reg <= '0;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                OP_CLEAR_PEAK:
                begin
                    peak_reg <= '0;
                end
                OP_CLEAR_ALL:
                begin
                    peak_reg  <= '0;
                    win0_reg  <= '0;
                    win1_reg  <= '0;
                    phase_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.mul && status.d_zero)
        begin
            peak_reg <= join_peak(peak_reg, {{2{y1_reg[SAMPLE_W-1]}}, y1_reg});
        end
        else if (cmd.join_fit)
        begin
            peak_reg <= join_peak(peak_reg, fit_value);
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            y1_reg <= win1_reg;
            d_reg  <= d_new;
            n_reg  <= n_new;
        end
        if (cmd.mul)
        begin
            nsq_reg <= prod[SQ_W-1:0];
        end
        if (cmd.div_init)
        begin
            rem_reg <= DEN_W'(dividend[SQ_W:QUO_W]);
            dvd_reg <= dividend[QUO_W-1:0];
            den_reg <= {ad[DEN_W-4:0], 3'b000};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], take};
        end
    end

    assign peak = peak_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> rem_reg < den_reg)
        else $error("Divider partial remainder not below the divisor.");

endmodule
